### sv/bol_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bounded ordered list.
// No dependencies; every other file of the block depends on this package.
package bol_pkg;

    localparam int DEF_LIST_DEPTH = 16;
    localparam int MODE_W         = 3;
    localparam int POS_W          = 5;
    localparam int DATA_W         = 32;
    localparam int COUNT_W        = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_INSERT     = 3'd2,
        MODE_POP_FRONT  = 3'd3,
        MODE_POP_BACK   = 3'd4,
        MODE_REMOVE     = 3'd5,
        MODE_READ       = 3'd6,
        MODE_CLEAR      = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE,
        OP_DROP_BACK,
        OP_READ,
        OP_CLEAR
    } t_op;

    typedef enum logic [1:0] {
        SEL_POS,
        SEL_FRONT,
        SEL_BACK
    } t_sel;

    typedef enum logic {
        OUT_EMPTY,
        OUT_FULL
    } t_out_state;

    typedef struct packed {
        logic exec;
        t_op  op;
        t_sel sel;
        logic ok;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic pos_lt_count;
        logic pos_le_count;
    } t_dp_stat;

endpackage

### sv/bol_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and result beats.
// Depends on bol_pkg for field widths.
interface bol_in_if;
    logic                             valid;
    logic                             ready;
    logic [bol_pkg::MODE_W-1:0]       mode;
    logic [bol_pkg::POS_W-1:0]        position;
    logic signed [bol_pkg::DATA_W-1:0] item_value;

    modport source (output valid, mode, position, item_value, input ready);
    modport sink   (input valid, mode, position, item_value, output ready);
endinterface

interface bol_out_if;
    logic                              valid;
    logic                              ready;
    logic                              ok;
    logic signed [bol_pkg::DATA_W-1:0] read_value;
    logic [bol_pkg::COUNT_W-1:0]       count_after;

    modport source (output valid, ok, read_value, count_after, input ready);
    modport sink   (input valid, ok, read_value, count_after, output ready);
endinterface

### sv/bol_ctrl.sv
`timescale 1ns / 1ps
// Controller: result-slot state machine and request decode.
// Depends on bol_pkg; drives the datapath through t_dp_cmd.
module bol_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  logic [bol_pkg::MODE_W-1:0] i_mode,
    input  bol_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output bol_pkg::t_dp_cmd  o_cmd
);
    import bol_pkg::*;

    t_out_state r_state;
    t_out_state n_state;
    logic       in_ready;
    logic       exec;

    assign in_ready = (r_state == OUT_EMPTY) || i_out_ready;
    assign exec     = i_in_valid && in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= OUT_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        if (exec) begin
            n_state = OUT_FULL;
        end else if (i_out_ready) begin
            n_state = OUT_EMPTY;
        end
    end

    always_comb begin
        o_in_ready  = in_ready;
        o_out_valid = (r_state == OUT_FULL);
    end

    // Decode the request; a rejected request only reports.
    always_comb begin
        o_cmd      = '0;
        o_cmd.exec = exec;
        o_cmd.op   = OP_NONE;
        o_cmd.sel  = SEL_POS;
        case (t_mode'(i_mode))
            MODE_PUSH_FRONT: begin
                o_cmd.ok  = !i_stat.full;
                o_cmd.op  = OP_INSERT;
                o_cmd.sel = SEL_FRONT;
            end
            MODE_PUSH_BACK: begin
                o_cmd.ok  = !i_stat.full;
                o_cmd.op  = OP_INSERT;
                o_cmd.sel = SEL_BACK;
            end
            MODE_INSERT: begin
                o_cmd.ok  = !i_stat.full && i_stat.pos_le_count;
                o_cmd.op  = OP_INSERT;
            end
            MODE_POP_FRONT: begin
                o_cmd.ok  = !i_stat.empty;
                o_cmd.op  = OP_REMOVE;
                o_cmd.sel = SEL_FRONT;
            end
            MODE_POP_BACK: begin
                o_cmd.ok  = !i_stat.empty;
                o_cmd.op  = OP_DROP_BACK;
            end
            MODE_REMOVE: begin
                o_cmd.ok  = i_stat.pos_lt_count;
                o_cmd.op  = OP_REMOVE;
            end
            MODE_READ: begin
                o_cmd.ok  = i_stat.pos_lt_count;
                o_cmd.op  = OP_READ;
            end
            MODE_CLEAR: begin
                o_cmd.ok  = 1'b1;
                o_cmd.op  = OP_CLEAR;
            end
            default: begin
                o_cmd.ok  = 1'b0;
            end
        endcase
        if (!o_cmd.ok) begin
            o_cmd.op = OP_NONE;
        end
    end

endmodule

### sv/bol_dpath.sv
`timescale 1ns / 1ps
// Datapath: row of entry cells that shift in place, entry count and result register.
// Depends on bol_pkg; commanded by bol_ctrl.
module bol_dpath #(
    parameter int LIST_DEPTH = bol_pkg::DEF_LIST_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bol_pkg::t_dp_cmd                  i_cmd,
    input  logic [bol_pkg::POS_W-1:0]         i_position,
    input  logic signed [bol_pkg::DATA_W-1:0] i_item_value,
    output bol_pkg::t_dp_stat                 o_stat,
    output logic                              o_ok,
    output logic signed [bol_pkg::DATA_W-1:0] o_read_value,
    output logic [bol_pkg::COUNT_W-1:0]       o_count_after
);
    import bol_pkg::*;

    localparam int CW   = $clog2(LIST_DEPTH + 1);
    localparam int IW   = $clog2(LIST_DEPTH);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic signed [DATA_W-1:0] r_cells [LIST_DEPTH];
    logic signed [DATA_W-1:0] n_cells [LIST_DEPTH];
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic                     r_ok;
    logic signed [DATA_W-1:0] r_read_value;
    logic [CW-1:0]            r_count_after;
    logic [CMPW-1:0]          pos_ext;
    logic [CMPW-1:0]          cnt_ext;
    logic [CMPW-1:0]          eff_pos;

    assign pos_ext = CMPW'(i_position);
    assign cnt_ext = CMPW'(r_count);

    always_comb begin
        o_stat.empty        = (r_count == '0);
        o_stat.full         = (r_count == CW'(LIST_DEPTH));
        o_stat.pos_lt_count = (pos_ext < cnt_ext);
        o_stat.pos_le_count = (pos_ext <= cnt_ext);
    end

    always_comb begin
        case (i_cmd.sel)
            SEL_FRONT: eff_pos = '0;
            SEL_BACK:  eff_pos = cnt_ext;
            default:   eff_pos = pos_ext;
        endcase
    end

    // Each cell looks only at its own neighbors: open or close a gap at eff_pos.
    for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
        logic signed [DATA_W-1:0] upper;
        logic signed [DATA_W-1:0] lower;

        if (k == 0) begin : g_first
            assign lower = r_cells[k];
        end else begin : g_inner_lo
            assign lower = r_cells[k-1];
        end
        if (k == LIST_DEPTH - 1) begin : g_last
            assign upper = r_cells[k];
        end else begin : g_inner_hi
            assign upper = r_cells[k+1];
        end

        always_comb begin
            n_cells[k] = r_cells[k];
            case (i_cmd.op)
                OP_INSERT: begin
                    if (CMPW'(k) == eff_pos) begin
                        n_cells[k] = i_item_value;
                    end else if (CMPW'(k) > eff_pos) begin
                        n_cells[k] = lower;
                    end
                end
                OP_REMOVE: begin
                    if (CMPW'(k) >= eff_pos) begin
                        n_cells[k] = upper;
                    end
                end
                default: begin
                    n_cells[k] = r_cells[k];
                end
            endcase
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.exec) begin
                r_cells[k] <= n_cells[k];
            end
        end
    end

    always_comb begin
        case (i_cmd.op)
            OP_INSERT:    n_count = r_count + CW'(1);
            OP_REMOVE:    n_count = r_count - CW'(1);
            OP_DROP_BACK: n_count = r_count - CW'(1);
            OP_CLEAR:     n_count = '0;
            default:      n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    // Result register; a read is only decoded when position is below the count.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_ok          <= i_cmd.ok;
            r_count_after <= n_count;
            if (i_cmd.op == OP_READ) begin
                r_read_value <= r_cells[pos_ext[IW-1:0]];
            end else begin
                r_read_value <= '0;
            end
        end
    end

    assign o_ok          = r_ok;
    assign o_read_value  = r_read_value;
    assign o_count_after = COUNT_W'(r_count_after);

endmodule

### sv/bounded_ordered_list.sv
`timescale 1ns / 1ps
// Bounded ordered list of up to LIST_DEPTH signed 32-bit values, front at position 0.
// Every request beat (push, insert, pop, remove, read, clear) gives exactly one result
// beat with ok, read_value and count_after. A request is executed in one step: the
// row of entry cells shifts all entries at once to open or close a gap, so the block takes
// one request per cycle as long as the result side keeps taking results; a result that
// is not taken holds the single result register and stalls further requests. The result is
// registered, shown in the cycle after acceptance. No clearing pass is needed after reset.
module bounded_ordered_list #(
    parameter int LIST_DEPTH = bol_pkg::DEF_LIST_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bol_in_if.sink    i_in,
    bol_out_if.source o_out
);
    import bol_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    bol_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_mode      (i_in.mode),
        .i_stat      (stat),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    bol_dpath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_position    (i_in.position),
        .i_item_value  (i_in.item_value),
        .o_stat        (stat),
        .o_ok          (o_out.ok),
        .o_read_value  (o_out.read_value),
        .o_count_after (o_out.count_after)
    );

endmodule

### sv/bol_checker.sv
`timescale 1ns / 1ps
// Port-level checks for bounded_ordered_list, attached by bind.
// Depends on bol_pkg for field widths.
module bol_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic                              i_ok,
    input logic signed [bol_pkg::DATA_W-1:0] i_read_value,
    input logic [bol_pkg::COUNT_W-1:0]       i_count_after
);
    import bol_pkg::*;

    // No result right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // Every accepted request shows its result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("accepted request gave no result");

    // A rejected request reports zero data.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_ok) |-> (i_read_value == '0))
        else $error("rejected request with nonzero read value");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_ok) && $stable(i_read_value)
             && $stable(i_count_after)))
        else $error("stalled result changed");

endmodule

bind bounded_ordered_list bol_checker u_bol_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_ok          (o_out.ok),
    .i_read_value  (o_out.read_value),
    .i_count_after (o_out.count_after)
);
